// File: rtl/tatc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tatc_pkg
// Shared constants for the transmit arrival time calculation unit.
// ----------------------------------------------------------------------------
package tatc_pkg;

  // transmit modes
  localparam logic [1:0] MODE_PLANE   = 2'd0;
  localparam logic [1:0] MODE_FOCUSED = 2'd1;
  localparam logic [1:0] MODE_DIVERGE = 2'd2;
  localparam logic [1:0] MODE_UNUSED  = 2'd3;

  // register indexes on the configuration port
  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_ORIGIN_X = 3'd1;
  localparam logic [2:0] REG_FOCUS_X  = 3'd2;
  localparam logic [2:0] REG_FOCUS_Y  = 3'd3;
  localparam logic [2:0] REG_FOCUS_Z  = 3'd4;
  localparam logic [2:0] REG_SIN      = 3'd5;
  localparam logic [2:0] REG_COS      = 3'd6;
  localparam logic [2:0] REG_SPEED    = 3'd7;

  localparam int ANGLE_W    = 16;
  localparam int SPEED_W    = 12;
  localparam int ANGLE_FRAC = 15;
  localparam int DIST_FRAC  = 10;
  localparam int OUT_W      = 23;
  localparam int QUOT_W     = 23;
  localparam int NS_PER_US  = 1000;

  localparam logic signed [ANGLE_W-1:0] COS_RESET   = 16'sd32767;
  localparam logic [SPEED_W-1:0]        SPEED_RESET = 12'd1540;

  localparam logic [OUT_W-1:0] OUT_POS_LIM = 23'h3FFFFF;
  localparam logic [OUT_W-1:0] OUT_NEG_LIM = 23'h400000;

endpackage

// File: rtl/transmit_arrival_time_calc_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// transmit_arrival_time_calc_unit
// Transmit arrival time of an image point for plane, focused and diverging
// transmits, in nanoseconds, rounded and saturated.
// ----------------------------------------------------------------------------
// pipeline: start runs through stages 0 to 3, the bit-per-stage square root,
//   stages 4 and 5, the divider and the output register before done rises
// throughput: one point per cycle, busy stays low, the receiver never stalls
// reset: synchronous rst clears all valid bits and loads register defaults
//   (plane wave, cos 32767, 1540 m/s); no clearing pass is needed
module transmit_arrival_time_calc_unit #(
  parameter int COORD_WIDTH = 19
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [COORD_WIDTH-1:0]       point_x,
  input  logic signed [COORD_WIDTH-1:0]       point_y,
  input  logic signed [COORD_WIDTH-1:0]       point_z,
  output logic                                done,
  output logic signed [tatc_pkg::OUT_W-1:0]   arrival_ns,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [4:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  localparam int CW    = COORD_WIDTH;
  localparam int DW    = CW + 1;
  localparam int PW    = 2 * DW;
  localparam int SUMW  = 2 * CW + 4;
  localparam int RW    = SUMW / 2 + tatc_pkg::DIST_FRAC;
  localparam int PLW   = DW + tatc_pkg::ANGLE_W;
  localparam int NUM_W = CW + 19;
  localparam int MAG_W = NUM_W - 1;
  localparam int SCL_W = MAG_W + 11;
  localparam int DVD_W = SCL_W - tatc_pkg::ANGLE_FRAC;
  localparam int FSH   = tatc_pkg::ANGLE_FRAC - tatc_pkg::DIST_FRAC;
  localparam int AW    = tatc_pkg::ANGLE_W;
  localparam int SPW   = tatc_pkg::SPEED_W;
  localparam int OW    = tatc_pkg::OUT_W;

  // ---------------- configuration registers ----------------
  logic [1:0]            transmit_mode;
  logic signed [CW-1:0]  origin_x, focus_x, focus_y, focus_z;
  logic signed [AW-1:0]  sin_angle, cos_angle;
  logic [SPW-1:0]        sound_speed;
  logic                  cfg_wr;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      transmit_mode <= tatc_pkg::MODE_PLANE;
      origin_x      <= '0;
      focus_x       <= '0;
      focus_y       <= '0;
      focus_z       <= '0;
      sin_angle     <= '0;
      cos_angle     <= tatc_pkg::COS_RESET;
      sound_speed   <= tatc_pkg::SPEED_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        tatc_pkg::REG_MODE:     transmit_mode <= pwdata[1:0];
        tatc_pkg::REG_ORIGIN_X: origin_x      <= pwdata[CW-1:0];
        tatc_pkg::REG_FOCUS_X:  focus_x       <= pwdata[CW-1:0];
        tatc_pkg::REG_FOCUS_Y:  focus_y       <= pwdata[CW-1:0];
        tatc_pkg::REG_FOCUS_Z:  focus_z       <= pwdata[CW-1:0];
        tatc_pkg::REG_SIN:      sin_angle     <= pwdata[AW-1:0];
        tatc_pkg::REG_COS:      cos_angle     <= pwdata[AW-1:0];
        tatc_pkg::REG_SPEED:    sound_speed   <= pwdata[SPW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      tatc_pkg::REG_MODE:     prdata = 32'(transmit_mode);
      tatc_pkg::REG_ORIGIN_X: prdata = 32'($unsigned(origin_x));
      tatc_pkg::REG_FOCUS_X:  prdata = 32'($unsigned(focus_x));
      tatc_pkg::REG_FOCUS_Y:  prdata = 32'($unsigned(focus_y));
      tatc_pkg::REG_FOCUS_Z:  prdata = 32'($unsigned(focus_z));
      tatc_pkg::REG_SIN:      prdata = 32'($unsigned(sin_angle));
      tatc_pkg::REG_COS:      prdata = 32'($unsigned(cos_angle));
      tatc_pkg::REG_SPEED:    prdata = 32'(sound_speed);
      default:                prdata = '0;
    endcase
  end

  // focus on the beam origin falls back to the point norm
  logic           axis_zero;
  logic [SPW-1:0] speed_eff;
  assign axis_zero = (focus_x == origin_x) && (focus_y == '0) && (focus_z == '0);
  assign speed_eff = (sound_speed == '0) ? SPW'(1) : sound_speed;

  // ---------------- stage 0: input register ----------------
  logic                 v0;
  logic signed [CW-1:0] p0x, p0y, p0z;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start && !busy;
    end
    if (start && !busy) begin
      p0x <= point_x;
      p0y <= point_y;
      p0z <= point_z;
    end
  end

  // ---------------- stage 1: differences ----------------
  logic                 v1;
  logic signed [DW-1:0] d1x, d1y, d1z, a1x, a1y, a1z, pdx1;
  logic signed [CW-1:0] pz1;
  logic signed [DW-1:0] rx, ry, rz;
  logic                 use_point;

  assign rx = DW'(p0x) - DW'(focus_x);
  assign ry = DW'(p0y) - DW'(focus_y);
  assign rz = DW'(p0z) - DW'(focus_z);
  assign use_point = (transmit_mode == tatc_pkg::MODE_FOCUSED) && axis_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
    d1x  <= use_point ? DW'(p0x) : rx;
    d1y  <= use_point ? DW'(p0y) : ry;
    d1z  <= use_point ? DW'(p0z) : rz;
    a1x  <= DW'(focus_x) - DW'(origin_x);
    a1y  <= DW'(focus_y);
    a1z  <= DW'(focus_z);
    pdx1 <= DW'(p0x) - DW'(origin_x);
    pz1  <= p0z;
  end

  // ---------------- stage 2: products ----------------
  logic                  v2;
  logic [PW-1:0]         sqd2x, sqd2y, sqd2z, sqa2x, sqa2y, sqa2z;
  logic signed [PW-1:0]  dt2x, dt2y, dt2z;
  logic signed [PLW-1:0] plx2, plz2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    sqd2x <= PW'(d1x) * PW'(d1x);
    sqd2y <= PW'(d1y) * PW'(d1y);
    sqd2z <= PW'(d1z) * PW'(d1z);
    sqa2x <= PW'(a1x) * PW'(a1x);
    sqa2y <= PW'(a1y) * PW'(a1y);
    sqa2z <= PW'(a1z) * PW'(a1z);
    dt2x  <= PW'(d1x) * PW'(a1x);
    dt2y  <= PW'(d1y) * PW'(a1y);
    dt2z  <= PW'(d1z) * PW'(a1z);
    plx2  <= PLW'(pdx1) * PLW'(sin_angle);
    plz2  <= PLW'(pz1) * PLW'(cos_angle);
  end

  // ---------------- stage 3: sums ----------------
  logic                    v3;
  logic [SUMW-1:0]         sd3, sa3;
  logic signed [SUMW-1:0]  dot_c;
  logic                    pos3;
  logic signed [NUM_W-1:0] pl3;

  assign dot_c = SUMW'(dt2x) + SUMW'(dt2y) + SUMW'(dt2z);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    sd3  <= SUMW'(sqd2x) + SUMW'(sqd2y) + SUMW'(sqd2z);
    sa3  <= SUMW'(sqa2x) + SUMW'(sqa2y) + SUMW'(sqa2z);
    pos3 <= !dot_c[SUMW-1];
    pl3  <= NUM_W'(plx2) + NUM_W'(plz2);
  end

  // ---------------- square roots, side data in a matching delay line ----
  logic [RW-1:0]           rd, ra;
  logic                    dl_v   [RW];
  logic                    dl_pos [RW];
  logic signed [NUM_W-1:0] dl_pl  [RW];

  tatc_sqrt #(.ROOT_W(RW)) u_sqrt_pt (
    .clk      (clk),
    .radicand ({sd3, {(2 * tatc_pkg::DIST_FRAC){1'b0}}}),
    .root     (rd)
  );

  tatc_sqrt #(.ROOT_W(RW)) u_sqrt_ax (
    .clk      (clk),
    .radicand ({sa3, {(2 * tatc_pkg::DIST_FRAC){1'b0}}}),
    .root     (ra)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      dl_v[0] <= 1'b0;
    end else begin
      dl_v[0] <= v3;
    end
    dl_pos[0] <= pos3;
    dl_pl[0]  <= pl3;
  end

  for (genvar k = 1; k < RW; k++) begin : g_delay
    always_ff @(posedge clk) begin
      if (rst) begin
        dl_v[k] <= 1'b0;
      end else begin
        dl_v[k] <= dl_v[k-1];
      end
      dl_pos[k] <= dl_pos[k-1];
      dl_pl[k]  <= dl_pl[k-1];
    end
  end

  // ---------------- stage 4: numerator select, all in Q.15 ----------------
  logic                    v4, neg4;
  logic [MAG_W-1:0]        mag4;
  logic signed [NUM_W-1:0] num_c, rdn, ran;

  assign rdn = NUM_W'(rd);
  assign ran = NUM_W'(ra);

  always_comb begin
    unique case (transmit_mode)
      tatc_pkg::MODE_PLANE:   num_c = dl_pl[RW-1];
      tatc_pkg::MODE_FOCUSED: begin
        if (axis_zero) begin
          num_c = rdn <<< FSH;
        end else if (dl_pos[RW-1]) begin
          num_c = (ran + rdn) <<< FSH;
        end else begin
          num_c = (ran - rdn) <<< FSH;
        end
      end
      tatc_pkg::MODE_DIVERGE: num_c = (rdn - ran) <<< FSH;
      default:                num_c = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= dl_v[RW-1];
    end
    neg4 <= num_c[NUM_W-1];
    mag4 <= num_c[NUM_W-1] ? MAG_W'(-num_c) : MAG_W'(num_c);
  end

  // ---------------- stage 5: scale to ns, add rounding half ----------------
  logic             v5, neg5;
  logic [DVD_W-1:0] dvd5;
  logic [SCL_W-1:0] scaled;

  assign scaled = SCL_W'(mag4) * SCL_W'(tatc_pkg::NS_PER_US)
                + (SCL_W'(speed_eff) << (tatc_pkg::ANGLE_FRAC - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    neg5 <= neg4;
    dvd5 <= scaled[SCL_W-1:tatc_pkg::ANGLE_FRAC];
  end

  // ---------------- divide by speed ----------------
  logic          dv_valid, dv_neg, dv_ovf;
  logic [OW-1:0] dv_quot;

  tatc_div #(.DVD_W(DVD_W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v5),
    .in_neg    (neg5),
    .dividend  (dvd5),
    .divisor   (speed_eff),
    .out_valid (dv_valid),
    .out_neg   (dv_neg),
    .out_ovf   (dv_ovf),
    .quot      (dv_quot)
  );

  // ---------------- output: saturate and apply sign ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_valid;
    end
    if (dv_neg) begin
      arrival_ns <= (dv_ovf || dv_quot > tatc_pkg::OUT_NEG_LIM) ?
                    tatc_pkg::OUT_NEG_LIM : OW'(-dv_quot);
    end else begin
      arrival_ns <= (dv_ovf || dv_quot > tatc_pkg::OUT_POS_LIM) ?
                    tatc_pkg::OUT_POS_LIM : dv_quot;
    end
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##(RW + 31) done)
    else $error("result transfer missing after start");

  a_neg_nonzero: assert property (@(posedge clk) disable iff (rst)
    v4 && neg4 |-> mag4 != '0)
    else $error("negative numerator with zero magnitude");

  a_unused_mode: assert property (@(posedge clk) disable iff (rst)
    dl_v[RW-1] && transmit_mode == tatc_pkg::MODE_UNUSED |=> mag4 == '0)
    else $error("unused mode gave nonzero numerator");

endmodule

// File: rtl/tatc_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tatc_sqrt
// Pipelined integer square root, one root bit resolved per stage.
// ----------------------------------------------------------------------------
module tatc_sqrt #(
  parameter int ROOT_W = 31
) (
  input  logic                  clk,
  input  logic [2*ROOT_W-1:0]   radicand,
  output logic [ROOT_W-1:0]     root
);

  localparam int RMW = ROOT_W + 2;

  logic [RMW-1:0]      rem_q  [ROOT_W];
  logic [ROOT_W-1:0]   root_q [ROOT_W];
  logic [2*ROOT_W-1:0] opd_q  [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [RMW-1:0]      rem_in;
    logic [ROOT_W-1:0]   root_in;
    logic [2*ROOT_W-1:0] opd_in;
    logic [RMW-1:0]      rem_sh;
    logic [RMW-1:0]      trial;
    logic                ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign opd_in  = radicand;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign opd_in  = opd_q[k-1];
    end

    // bring down the next two radicand bits
    assign rem_sh = {rem_in[ROOT_W-1:0], opd_in[2*ROOT_W-1 -: 2]};
    assign trial  = {root_in, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      rem_q[k]  <= ge ? (rem_sh - trial) : rem_sh;
      root_q[k] <= {root_in[ROOT_W-2:0], ge};
      opd_q[k]  <= opd_in << 2;
    end
  end

  assign root = root_q[ROOT_W-1];

endmodule

// File: rtl/tatc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tatc_div
// Pipelined restoring divider by the sound speed with overflow detect.
// ----------------------------------------------------------------------------
module tatc_div #(
  parameter int DVD_W = 33
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_neg,
  input  logic [DVD_W-1:0]              dividend,
  input  logic [tatc_pkg::SPEED_W-1:0]  divisor,
  output logic                          out_valid,
  output logic                          out_neg,
  output logic                          out_ovf,
  output logic [tatc_pkg::QUOT_W-1:0]   quot
);

  localparam int QW    = tatc_pkg::QUOT_W;
  localparam int SW    = tatc_pkg::SPEED_W;
  localparam int HI_W  = DVD_W - QW;
  localparam int CMP_W = (HI_W > SW) ? HI_W : SW;

  logic          vld_q [QW+1];
  logic          neg_q [QW+1];
  logic          ovf_q [QW+1];
  logic [SW-1:0] rem_q [QW+1];
  logic [QW-1:0] lo_q  [QW+1];
  logic [QW-1:0] quo_q [QW+1];

  logic [HI_W-1:0] hi;
  assign hi = dividend[DVD_W-1:QW];

  // entry stage: quotient needs more than QW bits when hi >= divisor
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= in_valid;
    end
    neg_q[0] <= in_neg;
    ovf_q[0] <= (CMP_W'(hi) >= CMP_W'(divisor));
    rem_q[0] <= SW'(hi);
    lo_q[0]  <= dividend[QW-1:0];
    quo_q[0] <= '0;
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    logic [SW:0] rem_sh;
    logic [SW:0] dsr;
    logic        ge;

    assign rem_sh = {rem_q[k-1], lo_q[k-1][QW-1]};
    assign dsr    = {1'b0, divisor};
    assign ge     = (rem_sh >= dsr);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_q[k-1];
      end
      neg_q[k] <= neg_q[k-1];
      ovf_q[k] <= ovf_q[k-1];
      rem_q[k] <= ge ? SW'(rem_sh - dsr) : SW'(rem_sh);
      lo_q[k]  <= lo_q[k-1] << 1;
      quo_q[k] <= {quo_q[k-1][QW-2:0], ge};
    end
  end

  assign out_valid = vld_q[QW];
  assign out_neg   = neg_q[QW];
  assign out_ovf   = ovf_q[QW];
  assign quot      = quo_q[QW];

  a_valid_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid |-> ##(QW+1) out_valid)
    else $error("divider valid lost in pipeline");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ovf && divisor != '0 |-> rem_q[QW] < divisor)
    else $error("divider remainder not below divisor");

  a_entry_rem: assert property (@(posedge clk) disable iff (rst)
    vld_q[0] && !ovf_q[0] |-> rem_q[0] < divisor)
    else $error("divider start remainder too large");

endmodule
